// ----- src/lbc_pkg.sv -----
package lbc_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int KEY_W   = 64;
  localparam int STAMP_W = 64;
  localparam int COST_W  = 31;
  localparam int PIN_W   = 16;
  localparam int BYTES_W = 36;
  localparam int DIM_W   = 15;

  localparam logic [DIM_W-1:0]   MAX_DIM        = DIM_W'(16384);
  localparam logic [PIN_W-1:0]   PIN_MAX        = '1;
  localparam logic [BYTES_W-1:0] DEFAULT_BUDGET = BYTES_W'(134217728);
  localparam logic [6:0]         EVICT_MAX      = 7'd127;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_INSERT  = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_RELEASE = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [63:0]      entry_key;
    logic [DIM_W-1:0] img_width;
    logic [DIM_W-1:0] img_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         slot_index;
    logic [6:0]         evicted_count;
    logic [BYTES_W-1:0] bytes_in_use;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    logic [COST_W-1:0]  cost;
    logic [PIN_W-1:0]   pins;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             v_we;
    logic [IDX_W-1:0] v_addr;
    logic             v_set;
  } mem_cmd_t;

  typedef struct packed {
    entry_t data;
    logic   valid;
  } mem_rsp_t;

endpackage

// ----- src/lru_budget_cache.sv -----
// lru_budget_cache: key-addressed resource cache held under a byte budget,
// with least-recently-used eviction of unpinned entries.
//
// Channels (valid/ready, a beat moves when both are high):
//   in   - one request beat: mode (acquire/release), entry_key, img_width,
//          img_height. in_ready is high only while no request is in flight.
//   out  - one result beat per request: status, slot_index, evicted_count,
//          bytes_in_use. Held in an output register until taken.
//   cfg  - budget_bytes write beat, always ready; write only while idle.
// Flow: every request first scans all 64 entries of the entry store
// (one read per cycle, through a registered read port), for a hit, a release
// and a miss alike; a miss then checks the budget and a free slot.
// Each eviction adds one more full scan for the oldest unpinned entry.
// The scan through the single read port of the entry store sets the rate.
// A new request is taken as soon as the previous result sits in the output
// register; if the receiver stalls with that register full, the finished
// result waits in the sequencer and no new request is taken.
// Reset (synchronous, rst high) clears all valid bits, bytes in use and the
// use clock, and loads the default budget of 128 MiB; it takes effect at once.
module lru_budget_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lbc_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lbc_pkg::out_item_t           out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lbc_pkg::BYTES_W-1:0]  cfg_data
);
  import lbc_pkg::*;

  logic [BYTES_W-1:0] budget;
  logic               seq_ready;
  logic               res_valid;
  logic               res_take;
  out_item_t          res;
  mem_cmd_t           cmd;
  mem_rsp_t           rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_ready;
  // move a finished result into the output register when it is empty or draining
  assign res_take  = res_valid && (!out_valid || out_ready);

  // budget register: hold until a config beat lands
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= DEFAULT_BUDGET;
    end else if (cfg_valid && cfg_ready) begin
      budget <= cfg_data;
    end
  end

  // output register: advance on take, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res;
    end
  end

  lbc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .in_item   (in_item),
    .ready     (seq_ready),
    .budget    (budget),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  lbc_store u_store (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

// ----- src/lbc_store.sv -----
module lbc_store (
  input  logic              clk,
  input  logic              rst,
  input  lbc_pkg::mem_cmd_t cmd,
  output lbc_pkg::mem_rsp_t rsp
);
  import lbc_pkg::*;

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] valid;

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rsp.data  <= mem[cmd.rd_addr];
      rsp.valid <= valid[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.v_we) begin
      valid[cmd.v_addr] <= cmd.v_set;
    end
  end

endmodule

// ----- src/lbc_seq.sv -----
module lbc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lbc_pkg::in_item_t             in_item,
  output logic                          ready,
  input  logic [lbc_pkg::BYTES_W-1:0]   budget,
  output logic                          res_valid,
  input  logic                          res_take,
  output lbc_pkg::out_item_t            res,
  output lbc_pkg::mem_cmd_t             cmd,
  input  lbc_pkg::mem_rsp_t             rsp
);
  import lbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_RESOLVE, S_CHECK, S_EVICT, S_EVDO, S_INSERT, S_DONE
  } state_t;

  state_t               state;
  in_item_t             item;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  entry_t               hit_ent;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;
  logic [STAMP_W-1:0]   pick_stamp;
  logic [COST_W-1:0]    pick_cost;
  logic [COST_W-1:0]    cost;
  logic [BYTES_W-1:0]   total;
  logic [STAMP_W-1:0]   use_clock;
  logic [6:0]           evicted;

  logic [DIM_W-1:0]     w_c;
  logic [DIM_W-1:0]     h_c;
  logic [2*DIM_W-1:0]   area;
  logic [COST_W-1:0]    cost_next;
  logic                 over;
  logic                 last_rd;
  logic [STAMP_W-1:0]   clock_next;
  logic [6:0]           evicted_next;

  assign w_c        = (item.img_width  > MAX_DIM) ? MAX_DIM : item.img_width;
  assign h_c        = (item.img_height > MAX_DIM) ? MAX_DIM : item.img_height;
  assign area       = (2*DIM_W)'(w_c) * (2*DIM_W)'(h_c);
  assign cost_next  = COST_W'({area, 2'b00});
  assign over       = ({1'b0, total} + (BYTES_W+1)'(cost)) > {1'b0, budget};
  assign last_rd    = rd_vld && (rd_idx == IDX_W'(SLOTS - 1));
  assign clock_next = use_clock + STAMP_W'(1);
  assign evicted_next = (evicted == EVICT_MAX) ? evicted : evicted + 7'd1;

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    cmd         = '0;
    cmd.rd_en   = (state == S_LOOK || state == S_EVICT) && (issue_cnt < CNT_W'(SLOTS));
    cmd.rd_addr = issue_cnt[IDX_W-1:0];
    unique case (state)
      S_RESOLVE: begin
        cmd.wr_addr = hit_idx;
        cmd.wr_data = hit_ent;
        if (hit_found && item.mode == MODE_RELEASE) begin
          cmd.wr_en        = (hit_ent.pins != '0);
          cmd.wr_data.pins = hit_ent.pins - PIN_W'(1);
        end else if (hit_found) begin
          cmd.wr_en         = 1'b1;
          cmd.wr_data.stamp = clock_next;
          cmd.wr_data.pins  = (hit_ent.pins == PIN_MAX) ? PIN_MAX : hit_ent.pins + PIN_W'(1);
        end
      end
      S_EVDO: begin
        cmd.v_we   = pick_found;
        cmd.v_addr = pick_idx;
        cmd.v_set  = 1'b0;
      end
      S_INSERT: begin
        cmd.wr_en         = 1'b1;
        cmd.wr_addr       = free_idx;
        cmd.wr_data.key   = item.entry_key;
        cmd.wr_data.stamp = clock_next;
        cmd.wr_data.cost  = cost;
        cmd.wr_data.pins  = PIN_W'(1);
        cmd.v_we          = 1'b1;
        cmd.v_addr        = free_idx;
        cmd.v_set         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      total     <= '0;
      use_clock <= '0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
        rd_idx    <= cmd.rd_addr;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item       <= in_item;
            issue_cnt  <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            evicted    <= '0;
            state      <= S_LOOK;
          end
        end
        S_LOOK: begin
          cost <= cost_next;
          if (rd_vld) begin
            if (rsp.valid && rsp.data.key == item.entry_key && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_ent   <= rsp.data;
            end
            if (!rsp.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
          if (last_rd) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (item.mode == MODE_RELEASE) begin
            res   <= '{ST_RELEASE, 6'd0, 7'd0, total};
            state <= S_DONE;
          end else if (hit_found) begin
            use_clock <= clock_next;
            res       <= '{ST_HIT, 6'(hit_idx), 7'd0, total};
            state     <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (over || !free_found) begin
            issue_cnt  <= '0;
            pick_found <= 1'b0;
            state      <= S_EVICT;
          end else begin
            state <= S_INSERT;
          end
        end
        S_EVICT: begin
          if (rd_vld && rsp.valid && rsp.data.pins == '0 &&
              (!pick_found || rsp.data.stamp < pick_stamp)) begin
            pick_found <= 1'b1;
            pick_idx   <= rd_idx;
            pick_stamp <= rsp.data.stamp;
            pick_cost  <= rsp.data.cost;
          end
          if (last_rd) begin
            state <= S_EVDO;
          end
        end
        S_EVDO: begin
          if (!pick_found) begin
            res   <= '{ST_REFUSED, 6'd0, evicted, total};
            state <= S_DONE;
          end else begin
            total   <= total - BYTES_W'(pick_cost);
            evicted <= evicted_next;
            if (!free_found || pick_idx < free_idx) begin
              free_found <= 1'b1;
              free_idx   <= pick_idx;
            end
            state <= S_CHECK;
          end
        end
        S_INSERT: begin
          use_clock <= clock_next;
          total     <= total + BYTES_W'(cost);
          res       <= '{ST_INSERT, 6'(free_idx), evicted, total + BYTES_W'(cost)};
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("entry store read and written in one cycle");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_LOOK || state == S_EVICT))
    else $error("read data returned outside a scan");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> (use_clock == $past(use_clock) + STAMP_W'(1)))
    else $error("use clock did not advance on insert");

  a_insert_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.status == ST_INSERT) |-> (res.bytes_in_use <= budget))
    else $error("insert left bytes in use above budget");

endmodule

// ----- tb/lru_budget_cache_test.sv -----
module lru_budget_cache_test;
  import lbc_pkg::*;

  // Pixel size used to turn a width and height into a byte cost.
  localparam int BYTES_PER_PIXEL = 4;
  // Longest wait either side draws before offering or taking a beat.
  localparam int STALL_MAX = 11;
  // A miss may run up to one full scan per eviction, and there can be
  // 64 evictions plus a stalled receiver. Allow far more.
  localparam int HANG_LIMIT = 40000;
  // Cycles to keep watching the result port once nothing is expected.
  localparam int DRAIN_CYCLES = 80;

  // Shadow copy of the cache. Each accepted request beat is run through the
  // same lookup, eviction and insert rules the block applies, and the result
  // it should produce is queued; result beats are checked in order.
  class cache_scoreboard;
    logic               live   [SLOTS];
    logic [KEY_W-1:0]   tag    [SLOTS];
    logic [STAMP_W-1:0] age    [SLOTS];
    logic [COST_W-1:0]  charge [SLOTS];
    logic [PIN_W-1:0]   refs   [SLOTS];
    logic [BYTES_W-1:0] held;
    logic [STAMP_W-1:0] tick;
    logic [BYTES_W-1:0] budget;
    out_item_t          awaited[$];
    int                 mismatches;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      held = '0;
      tick = '0;
      budget = DEFAULT_BUDGET;
      mismatches = 0;
    endfunction

    function void set_budget(logic [BYTES_W-1:0] b);
      budget = b;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function int lookup(logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && tag[i] == k) return i;
      return -1;
    endfunction

    function int lowest_free();
      for (int i = 0; i < SLOTS; i++)
        if (!live[i]) return i;
      return -1;
    endfunction

    // Evict the oldest unpinned entry; ties go to the lowest slot.
    function bit drop_oldest();
      int pick;
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i] && refs[i] == '0)
          if (pick < 0 || age[i] < age[pick]) pick = i;
      end
      if (pick < 0) return 1'b0;
      live[pick] = 1'b0;
      held = held - BYTES_W'(charge[pick]);
      return 1'b1;
    endfunction

    // Pick a random cached key that still holds pins, if there is one.
    function bit pinned_key(output logic [KEY_W-1:0] k);
      int idx[$];
      k = '0;
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && refs[i] != '0) idx.insert(idx.size(), i);
      if (idx.size() == 0) return 1'b0;
      k = tag[idx[$urandom_range(0, idx.size() - 1)]];
      return 1'b1;
    endfunction

    function void note_request(in_item_t req);
      out_item_t         res;
      int                s;
      int                f;
      int                evicted;
      bit                refused;
      logic [DIM_W-1:0]  w;
      logic [DIM_W-1:0]  h;
      logic [COST_W-1:0] cost;
      s = lookup(req.entry_key);
      res = '0;
      evicted = 0;
      refused = 1'b0;
      if (req.mode == MODE_RELEASE) begin
        // unknown key or zero pins: nothing moves
        if (s >= 0 && refs[s] != '0) refs[s] = refs[s] - PIN_W'(1);
        res.status = ST_RELEASE;
      end else if (s >= 0) begin
        tick = tick + STAMP_W'(1);
        age[s] = tick;
        if (refs[s] != PIN_MAX) refs[s] = refs[s] + PIN_W'(1);
        res.status = ST_HIT;
        res.slot_index = 6'(s);
      end else begin
        w = (req.img_width > MAX_DIM) ? MAX_DIM : req.img_width;
        h = (req.img_height > MAX_DIM) ? MAX_DIM : req.img_height;
        cost = COST_W'(w) * COST_W'(h) * COST_W'(BYTES_PER_PIXEL);
        // widen by one bit so the sum cannot wrap before the compare
        while (({1'b0, held} + (BYTES_W+1)'(cost)) > {1'b0, budget}) begin
          if (!drop_oldest()) begin
            refused = 1'b1;
            break;
          end
          evicted++;
        end
        if (!refused && lowest_free() < 0) begin
          if (drop_oldest()) evicted++;
          else refused = 1'b1;
        end
        if (refused) begin
          res.status = ST_REFUSED;
        end else begin
          f = lowest_free();
          tick = tick + STAMP_W'(1);
          live[f] = 1'b1;
          tag[f] = req.entry_key;
          age[f] = tick;
          charge[f] = cost;
          refs[f] = PIN_W'(1);
          held = held + BYTES_W'(cost);
          res.status = ST_INSERT;
          res.slot_index = 6'(f);
        end
      end
      res.evicted_count = (evicted > int'(EVICT_MAX)) ? EVICT_MAX : 7'(evicted);
      res.bytes_in_use = held;
      awaited.insert(awaited.size(), res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d slot %0d evicted %0d bytes %0d",
                   got.status, got.slot_index, got.evicted_count, got.bytes_in_use);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.evicted_count !== want.evicted_count ||
          got.bytes_in_use !== want.bytes_in_use) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp/got: status %0d/%0d slot %0d/%0d evicted %0d/%0d bytes %0d/%0d",
                   want.status, got.status, want.slot_index, got.slot_index,
                   want.evicted_count, got.evicted_count,
                   want.bytes_in_use, got.bytes_in_use);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [BYTES_W-1:0] cfg_data = '0;

  // When set, both sides run back to back with no idle cycles.
  bit                 calm = 1'b0;
  int                 idle_cycles = 0;
  cache_scoreboard    sb = new();

  always #10 clk = ~clk;

  lru_budget_cache u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Check every result beat against the oldest queued expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  // Count cycles in which no beat moves on any channel; give up past the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // Mostly sizes up to the phase's scale, with zeros and the full 15-bit
  // range (oversized values included) mixed in.
  function automatic logic [DIM_W-1:0] draw_dim(int top);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
    return DIM_W'($urandom_range(1, top));
  endfunction

  // Result side: stall a random number of cycles, then hold ready until a
  // beat is taken. Keep ready high across back-to-back beats.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request beat after a random gap and hold it until taken.
  // Valid is only lowered when a gap follows, never lowered and raised in
  // the same step.
  task automatic send_request(in_item_t req);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic acquire_entry(logic [KEY_W-1:0] k, logic [DIM_W-1:0] w,
                               logic [DIM_W-1:0] h);
    in_item_t req;
    req.mode = MODE_ACQUIRE;
    req.entry_key = k;
    req.img_width = w;
    req.img_height = h;
    send_request(req);
  endtask

  task automatic release_entry(logic [KEY_W-1:0] k);
    in_item_t req;
    req.mode = MODE_RELEASE;
    req.entry_key = k;
    req.img_width = '1;
    req.img_height = '0;
    send_request(req);
  endtask

  // Drop the request valid, let every outstanding result drain, then write
  // the budget while the block sits idle.
  task automatic write_budget(logic [BYTES_W-1:0] b);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_budget(b);
  endtask

  // One budget setting, then a run of requests over a fresh key pool.
  // Half are acquires, mostly of pool keys (hits and misses), most of the rest
  // release a key that still holds pins so the cache does not clog, and a
  // tenth are stray releases of unknown keys or of random pool keys.
  task automatic run_phase(logic [BYTES_W-1:0] b, int dim_top, int pool_size,
                           int count);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] k;
    in_item_t         req;
    int               roll;
    write_budget(b);
    calm = ($urandom_range(0, 3) == 0);
    repeat (pool_size) pool.insert(pool.size(), {$urandom, $urandom});
    repeat (count) begin
      roll = $urandom_range(0, 99);
      req.img_width = draw_dim(dim_top);
      req.img_height = draw_dim(dim_top);
      req.entry_key = pool[$urandom_range(0, pool_size - 1)];
      if (roll < 50) begin
        req.mode = MODE_ACQUIRE;
        if (roll < 4) req.entry_key = {$urandom, $urandom};
      end else if (roll < 90) begin
        req.mode = MODE_RELEASE;
        if (sb.pinned_key(k)) req.entry_key = k;
      end else begin
        req.mode = MODE_RELEASE;
        if (roll < 95) req.entry_key = {$urandom, $urandom};
      end
      send_request(req);
      // flip between idling and back-to-back stretches now and then
      if ($urandom_range(0, 49) == 0) calm = !calm;
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k_zero;
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_mix;
    k_zero = '0;
    k_ones = '1;
    k_mix = 64'hA5A5_5A5A_0F0F_F0F0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset budget of 128 MiB.
    acquire_entry(k_zero, '0, '0);          // zero-cost insert into slot 0
    acquire_entry(k_zero, '1, '1);          // hit, size ignored
    release_entry(k_zero);
    release_entry(k_zero);                  // pins back to zero
    release_entry(k_zero);                  // zero pins: no change
    release_entry(k_mix);                   // unknown key
    acquire_entry(k_ones, MAX_DIM, MAX_DIM); // evict the unpinned entry, refuse
    acquire_entry(k_ones, '1, '1);          // oversized both, clamped, refused
    acquire_entry(k_mix, DIM_W'(1), '1);    // oversized height only
    acquire_entry(k_ones, '1, DIM_W'(1));   // oversized width only
    acquire_entry(k_mix, '0, '0);           // hit
    release_entry(k_mix);
    release_entry(k_mix);
    acquire_entry(KEY_W'(1), DIM_W'(4096), DIM_W'(4096)); // fits the budget
    acquire_entry(KEY_W'(2), DIM_W'(4096), DIM_W'(4096)); // evict one, refuse
    release_entry(k_ones);
    release_entry(KEY_W'(1));

    // Random phases over a spread of budgets. Small pools give hits, large
    // ones fill the slot table; shrinking the budget below what is held
    // forces the next miss to evict down to it.
    run_phase(DEFAULT_BUDGET, 2048, 24, 150);
    run_phase('1, 64, 90, 150);
    run_phase('0, 16, 20, 100);
    run_phase(BYTES_W'(4096), 16, 30, 150);
    run_phase(BYTES_W'(1 << 20), 256, 40, 150);
    run_phase({4'($urandom_range(0, 15)), 32'($urandom)}, 16384, 70, 150);
    run_phase(BYTES_W'(1 << 16), 64, 40, 150);
    run_phase(DEFAULT_BUDGET, 4096, 24, 150);

    // Drain, then keep watching the result port for strays.
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/lbc_pkg.sv
src/lbc_store.sv
src/lbc_seq.sv
src/lru_budget_cache.sv
tb/lru_budget_cache_test.sv
